// ===== design/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Holds the store geometry, operation and status codes, the controller
// states and the helpers that move values between port and store widths.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Store geometry and field widths.
  localparam int STORE_DEPTH = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CAP_W       = 8;
  localparam int DATA_W      = 32;

  // Capacity after reset, limited to the store depth, kept as capacity - 1.
  localparam int CAP_RESET    = 10;
  localparam int CAP_M1_RESET = ((CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : CAP_RESET) - 1;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_REAR  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_REAR   = 2'd3
  } func_t;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RES  = 1'b1
  } state_t;

  // Port value to store width (sign-extend or truncate).
  function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [DATA_W-1:0] v);
    logic signed [63:0] w;
    w = $signed(v);
    return w[VALUE_WIDTH-1:0];
  endfunction

  // Store value to port width (sign-extend, then cut).
  function automatic logic [DATA_W-1:0] from_store(input logic [VALUE_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = $signed(v);
    return w[DATA_W-1:0];
  endfunction

endpackage

// ===== design/cdq_in_if.sv =====
// ----------------------------------------------------------------------------
// cdq_in_if: request channel of the circular deque
// Carries one operation code and the value for a push.
// ----------------------------------------------------------------------------
interface cdq_in_if;

  logic                              valid;
  logic                              ready;
  cdq_pkg::func_t                    func;
  logic signed [cdq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);

endinterface

// ===== design/cdq_out_if.sv =====
// ----------------------------------------------------------------------------
// cdq_out_if: result channel of the circular deque
// Carries the status of one request and the deque state after it.
// ----------------------------------------------------------------------------
interface cdq_out_if;

  logic                              valid;
  logic                              ready;
  cdq_pkg::status_t                  status;
  logic                              is_empty;
  logic                              is_full;
  logic signed [cdq_pkg::DATA_W-1:0] front_value;
  logic signed [cdq_pkg::DATA_W-1:0] rear_value;

  modport source (output valid, output status, output is_empty, output is_full,
                  output front_value, output rear_value, input ready);
  modport sink   (input valid, input status, input is_empty, input is_full,
                  input front_value, input rear_value, output ready);

endinterface

// ===== design/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a circular store with separate ports
// Requests on in_ch push or pop at either end; every request gives exactly
// one result on out_ch with the status, the empty and full flags and the
// front and rear values (all ones when the deque is empty).
//
// Usage notes:
//  - in_ch takes a request when valid and ready are high at a clock edge.
//    Each request passes through the accept cycle, in which indices and a
//    pushed entry are updated and the store is read, and the result state
//    S_RES, in which the registered read data of the store returns. The
//    store's single registered read port is why the result state is needed.
//  - The result is loaded into an output register in S_RES once that
//    register is free, which raises out_ch.valid; a new request is taken
//    only after the result of the last one has been loaded.
//  - If out_ch stalls, the block still takes one more request and holds its
//    result until the output register frees up; then in_ch ready stays low.
//  - cfg_we writes the capacity (zero acts as one, values above the store
//    depth act as the depth) and empties the deque. Write it only when idle.
//  - Reset (rst_n low, synchronous) empties the deque and sets capacity 10.
//    Store contents are not cleared; only live entries are ever read.
// ----------------------------------------------------------------------------
module circular_deque (
  input  logic                        clk,
  input  logic                        rst_n,
  cdq_in_if.sink                      in_ch,
  cdq_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int IW = cdq_pkg::IDX_W;
  localparam int VW = cdq_pkg::VALUE_WIDTH;
  localparam int DW = cdq_pkg::DATA_W;

  // Control and state registers.
  cdq_pkg::state_t  state_r, state_nxt;
  logic [IW-1:0]    front_r, front_nxt;
  logic [IW-1:0]    rear_r, rear_nxt;
  logic             empty_r, empty_nxt;
  logic [IW-1:0]    cm1_r, cm1_nxt;
  logic             rd_front_r, rd_front_nxt;
  logic             rd_rear_r, rd_rear_nxt;
  cdq_pkg::status_t status_r, status_nxt;
  logic [DW-1:0]    front_val_r, front_val_nxt;
  logic [DW-1:0]    rear_val_r, rear_val_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  cdq_pkg::status_t out_status_r, out_status_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_full_r, out_full_nxt;
  logic [DW-1:0]    out_front_r, out_front_nxt;
  logic [DW-1:0]    out_rear_r, out_rear_nxt;

  // Store and its ports.
  logic [VW-1:0]    mem [cdq_pkg::STORE_DEPTH];
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [VW-1:0]    mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  logic [VW-1:0]    rd_data_r;

  logic             accept;
  logic             full_now;
  logic [IW-1:0]    front_dec, front_inc, rear_dec, rear_inc;
  logic [DW-1:0]    fv, rv;

  // Full flag of the current (already updated) indices.
  assign full_now = !empty_r &&
                    (((front_r == '0) && (rear_r == cm1_r)) ||
                     ((IW+1)'(front_r) == (IW+1)'(rear_r) + 1'b1));

  // Wrapping neighbors of both indices.
  assign front_dec = (front_r == '0) ? cm1_r : front_r - 1'b1;
  assign front_inc = (front_r >= cm1_r) ? '0 : front_r + 1'b1;
  assign rear_dec  = (rear_r == '0) ? cm1_r : rear_r - 1'b1;
  assign rear_inc  = (rear_r >= cm1_r) ? '0 : rear_r + 1'b1;

  // A request is taken whenever the controller is idle.
  assign accept = in_ch.valid && (state_r == cdq_pkg::S_IDLE);

  // End values after a pop pick up the store read data.
  assign fv = rd_front_r ? cdq_pkg::from_store(rd_data_r) : front_val_r;
  assign rv = rd_rear_r  ? cdq_pkg::from_store(rd_data_r) : rear_val_r;

  // Next state, request handling and result formation.
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    empty_nxt      = empty_r;
    cm1_nxt        = cm1_r;
    rd_front_nxt   = rd_front_r;
    rd_rear_nxt    = rd_rear_r;
    status_nxt     = status_r;
    front_val_nxt  = front_val_r;
    rear_val_nxt   = rear_val_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    out_front_nxt  = out_front_r;
    out_rear_nxt   = out_rear_r;
    mem_we         = 1'b0;
    mem_waddr      = front_r;
    mem_wdata      = cdq_pkg::to_store(in_ch.push_value);
    mem_re         = 1'b0;
    mem_raddr      = front_r;
    in_ch.ready    = 1'b0;

    unique case (state_r)
      cdq_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          state_nxt    = cdq_pkg::S_RES;
          status_nxt   = cdq_pkg::ST_DONE;
          rd_front_nxt = 1'b0;
          rd_rear_nxt  = 1'b0;
          unique case (in_ch.func)
            cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
              if (full_now) begin
                status_nxt = cdq_pkg::ST_OVERFLOW;
              end else if (empty_r) begin
                // First entry always lands in slot zero.
                front_nxt     = '0;
                rear_nxt      = '0;
                empty_nxt     = 1'b0;
                mem_we        = 1'b1;
                mem_waddr     = '0;
                front_val_nxt = cdq_pkg::from_store(mem_wdata);
                rear_val_nxt  = cdq_pkg::from_store(mem_wdata);
              end else if (in_ch.func == cdq_pkg::FN_PUSH_FRONT) begin
                front_nxt     = front_dec;
                mem_we        = 1'b1;
                mem_waddr     = front_dec;
                front_val_nxt = cdq_pkg::from_store(mem_wdata);
              end else begin
                rear_nxt     = rear_inc;
                mem_we       = 1'b1;
                mem_waddr    = rear_inc;
                rear_val_nxt = cdq_pkg::from_store(mem_wdata);
              end
            end
            default: begin
              if (empty_r) begin
                status_nxt = cdq_pkg::ST_UNDERFLOW;
              end else if (front_r == rear_r) begin
                // Last entry leaves: the deque is empty again.
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b1;
              end else if (in_ch.func == cdq_pkg::FN_POP_FRONT) begin
                front_nxt    = front_inc;
                mem_re       = 1'b1;
                mem_raddr    = front_inc;
                rd_front_nxt = 1'b1;
              end else begin
                rear_nxt    = rear_dec;
                mem_re      = 1'b1;
                mem_raddr   = rear_dec;
                rd_rear_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      cdq_pkg::S_RES: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          state_nxt      = cdq_pkg::S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_empty_nxt  = empty_r;
          out_full_nxt   = full_now;
          out_front_nxt  = empty_r ? '1 : fv;
          out_rear_nxt   = empty_r ? '1 : rv;
          front_val_nxt  = fv;
          rear_val_nxt   = rv;
          rd_front_nxt   = 1'b0;
          rd_rear_nxt    = 1'b0;
        end
      end
      default: begin
        state_nxt = cdq_pkg::S_IDLE;
      end
    endcase

    // A capacity write empties the deque.
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cm1_nxt = '0;
      end else if (32'(cfg_wdata) > 32'(cdq_pkg::STORE_DEPTH)) begin
        cm1_nxt = IW'(cdq_pkg::STORE_DEPTH - 1);
      end else begin
        cm1_nxt = IW'(cfg_wdata - 1'b1);
      end
      front_nxt = '0;
      rear_nxt  = '0;
      empty_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdq_pkg::S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      cm1_r       <= IW'(cdq_pkg::CAP_M1_RESET);
      rd_front_r  <= 1'b0;
      rd_rear_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      cm1_r       <= cm1_nxt;
      rd_front_r  <= rd_front_nxt;
      rd_rear_r   <= rd_rear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    front_val_r  <= front_val_nxt;
    rear_val_r   <= rear_val_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
    out_front_r  <= out_front_nxt;
    out_rear_r   <= out_rear_nxt;
  end

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Result channel.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.is_full     = out_full_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.rear_value  = out_rear_r;

  // Both indices stay inside the configured capacity.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r <= cm1_r) && (rear_r <= cm1_r))
    else $error("deque index beyond capacity");

  // An empty deque always has both indices at zero.
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> ((front_r == '0) && (rear_r == '0)))
    else $error("empty deque with nonzero index");

  // An accepted request is always followed by the result cycle.
  a_acc_res: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == cdq_pkg::S_RES))
    else $error("accepted request not followed by result state");

  // An empty result reports all ones at both ends.
  a_empty_vals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_empty) |->
      ((out_ch.front_value == '1) && (out_ch.rear_value == '1)))
    else $error("empty result with live end values");

  // A refused push leaves the deque full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == cdq_pkg::ST_OVERFLOW)) |-> out_ch.is_full)
    else $error("overflow reported while not full");

endmodule
